// ----- src/pae_pkg.sv -----
package pae_pkg;

  localparam int TABLE_POINTS = 24;
  localparam int IDX_W        = $clog2(TABLE_POINTS);

  localparam int SP_W  = 12;  // static pressure, 0.01 inHg
  localparam int OUT_W = 18;  // altitude outputs, ft
  localparam int P_W   = 13;  // table pressure difference, 0.01 inHg
  localparam int A_W   = 25;  // table altitude, 0.01 ft
  localparam int SL_W  = A_W + 1;
  localparam int NUM_W = 41;  // interpolated numerator and divider width
  localparam int Q_W   = 15;  // quotient bits: |alt| / 10 ft stays below 2^15
  localparam int MAG_W = Q_W + 7;

  localparam logic signed [P_W-1:0] SEA_LEVEL = P_W'(2992);

  localparam logic [13:0] HALF_10  = 14'd500;
  localparam logic [13:0] HALF_100 = 14'd5000;
  localparam logic [13:0] UNIT_10  = 14'd1000;
  localparam logic [13:0] UNIT_100 = 14'd10000;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_STEP,
    OP_SEG,
    OP_MUL,
    OP_SUM,
    OP_BIAS,
    OP_ABS,
    OP_DIV,
    OP_SCALE,
    OP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   sel100;  // 1: round to 100 ft, 0: round to 10 ft
  } dp_cmd_t;

  typedef struct packed {
    logic hit;   // table entry at index is at or above the difference
    logic last;  // index is at the final entry
  } dp_stat_t;

  function automatic logic signed [P_W-1:0] rom_p(input logic [IDX_W-1:0] idx);
    logic signed [P_W-1:0] v;
    case (idx)
      0:       v = -P_W'(841);
      1:       v = P_W'(0);
      2:       v = P_W'(305);
      3:       v = P_W'(586);
      4:       v = P_W'(841);
      5:       v = P_W'(1074);
      6:       v = P_W'(1287);
      7:       v = P_W'(1478);
      8:       v = P_W'(1655);
      9:       v = P_W'(1813);
      10:      v = P_W'(1962);
      11:      v = P_W'(2082);
      12:      v = P_W'(2196);
      13:      v = P_W'(2301);
      14:      v = P_W'(2391);
      15:      v = P_W'(2471);
      16:      v = P_W'(2540);
      17:      v = P_W'(2600);
      18:      v = P_W'(2651);
      19:      v = P_W'(2696);
      20:      v = P_W'(2735);
      21:      v = P_W'(2768);
      22:      v = P_W'(2798);
      default: v = P_W'(2962);
    endcase
    return v;
  endfunction

  function automatic logic signed [A_W-1:0] rom_a(input logic [IDX_W-1:0] idx);
    logic signed [A_W-1:0] v;
    case (idx)
      0:       v = -A_W'(885827);
      1:       v = A_W'(0);
      2:       v = A_W'(295276);
      3:       v = A_W'(590551);
      4:       v = A_W'(885827);
      5:       v = A_W'(1181102);
      6:       v = A_W'(1476378);
      7:       v = A_W'(1771654);
      8:       v = A_W'(2066929);
      9:       v = A_W'(2362205);
      10:      v = A_W'(2657480);
      11:      v = A_W'(2952756);
      12:      v = A_W'(3248031);
      13:      v = A_W'(3543307);
      14:      v = A_W'(3838583);
      15:      v = A_W'(4133858);
      16:      v = A_W'(4429134);
      17:      v = A_W'(4724409);
      18:      v = A_W'(5019685);
      19:      v = A_W'(5314961);
      20:      v = A_W'(5610236);
      21:      v = A_W'(5905512);
      22:      v = A_W'(6200787);
      default: v = A_W'(10000000);
    endcase
    return v;
  endfunction

endpackage

// ----- src/pae_dp.sv -----
module pae_dp
  import pae_pkg::*;
(
  input  logic                    clk,
  input  dp_cmd_t                 cmd,
  input  logic [SP_W-1:0]         static_pressure,
  output dp_stat_t                stat,
  output logic signed [OUT_W-1:0] pressure_altitude,
  output logic signed [OUT_W-1:0] mode_c_altitude
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_POINTS - 1);

  logic signed [P_W-1:0]   d_r;
  logic [IDX_W-1:0]        idx_r;
  logic signed [A_W-1:0]   base_r;
  logic signed [SL_W-1:0]  slope_r;
  logic [P_W-1:0]          den_r;
  logic [P_W-1:0]          dd_r;
  logic signed [NUM_W-1:0] prod0_r;
  logic signed [NUM_W-1:0] prod1_r;
  logic signed [NUM_W-1:0] num_r;
  logic signed [NUM_W-1:0] biased_r;
  logic [NUM_W-1:0]        rem_r;
  logic [NUM_W-1:0]        div_r;
  logic                    neg_r;
  logic [Q_W-1:0]          q_r;
  logic signed [OUT_W-1:0] pa_r;
  logic signed [OUT_W-1:0] mc_r;
  logic signed [OUT_W-1:0] out_pa_r;
  logic signed [OUT_W-1:0] out_mc_r;

  logic signed [P_W-1:0]   p0, p1;
  logic signed [A_W-1:0]   a0, a1;
  logic signed [P_W:0]     seg_w;
  logic signed [P_W:0]     d_off;
  logic                    hit;
  logic [13:0]             half_k, unit_k;
  logic [MAG_W-1:0]        mag;
  logic signed [OUT_W-1:0] rounded;

  always_comb begin
    p1     = rom_p(idx_r);
    p0     = rom_p(idx_r - 1'b1);
    a1     = rom_a(idx_r);
    a0     = rom_a(idx_r - 1'b1);
    seg_w  = {p1[P_W-1], p1} - {p0[P_W-1], p0};
    d_off  = {d_r[P_W-1], d_r} - {p0[P_W-1], p0};
    hit    = (p1 >= d_r);
    half_k = cmd.sel100 ? HALF_100 : HALF_10;
    unit_k = cmd.sel100 ? UNIT_100 : UNIT_10;
    mag    = cmd.sel100 ? MAG_W'(q_r) * MAG_W'(100) : MAG_W'(q_r) * MAG_W'(10);
    rounded = neg_r ? -OUT_W'(mag) : OUT_W'(mag);
  end

  assign stat.hit  = hit;
  assign stat.last = (idx_r == LAST_IDX);

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        d_r   <= SEA_LEVEL - $signed({1'b0, static_pressure});
        idx_r <= '0;
      end
      OP_STEP: begin
        idx_r <= idx_r + 1'b1;
      end
      OP_SEG: begin
        // clamped cases collapse to base * 1 + 0
        if (!hit) begin
          base_r  <= rom_a(LAST_IDX);
          slope_r <= '0;
          den_r   <= P_W'(1);
          dd_r    <= '0;
        end else if (idx_r == '0) begin
          base_r  <= a1;
          slope_r <= '0;
          den_r   <= P_W'(1);
          dd_r    <= '0;
        end else if (seg_w <= 0) begin
          base_r  <= a1;
          slope_r <= '0;
          den_r   <= P_W'(1);
          dd_r    <= '0;
        end else begin
          base_r  <= a0;
          slope_r <= {a1[A_W-1], a1} - {a0[A_W-1], a0};
          den_r   <= seg_w[P_W-1:0];
          dd_r    <= d_off[P_W-1:0];
        end
      end
      OP_MUL: begin
        prod0_r <= NUM_W'(base_r * $signed({1'b0, den_r}));
        prod1_r <= NUM_W'(slope_r * $signed({1'b0, dd_r}));
      end
      OP_SUM: begin
        num_r <= prod0_r + prod1_r;
      end
      OP_BIAS: begin
        biased_r <= num_r + $signed(NUM_W'(den_r) * NUM_W'(half_k));
        div_r    <= (NUM_W'(den_r) * NUM_W'(unit_k)) << (Q_W - 1);
      end
      OP_ABS: begin
        neg_r <= biased_r[NUM_W-1];
        rem_r <= biased_r[NUM_W-1] ? NUM_W'(-biased_r) : NUM_W'(biased_r);
        q_r   <= '0;
      end
      OP_DIV: begin
        if (rem_r >= div_r) begin
          rem_r <= rem_r - div_r;
          q_r   <= {q_r[Q_W-2:0], 1'b1};
        end else begin
          q_r   <= {q_r[Q_W-2:0], 1'b0};
        end
        div_r <= div_r >> 1;
      end
      OP_SCALE: begin
        if (cmd.sel100) begin
          mc_r <= rounded;
        end else begin
          pa_r <= rounded;
        end
      end
      OP_PUBLISH: begin
        out_pa_r <= pa_r;
        out_mc_r <= mc_r;
      end
      default: begin
      end
    endcase
  end

  assign pressure_altitude = out_pa_r;
  assign mode_c_altitude   = out_mc_r;

endmodule

// ----- src/pae_ctrl.sv -----
module pae_ctrl
  import pae_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_service,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam int CNT_W = $clog2(Q_W);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_SEG,
    S_MUL,
    S_SUM,
    S_BIAS,
    S_ABS,
    S_DIV,
    S_SCALE,
    S_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             sel100_r, sel100_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sel100_nxt    = sel100_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    cmd.sel100    = sel100_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          if (in_service) begin
            state_nxt = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (stat.hit || stat.last) begin
          state_nxt = S_SEG;
        end else begin
          cmd.op = OP_STEP;
        end
      end
      S_SEG: begin
        cmd.op     = OP_SEG;
        sel100_nxt = 1'b0;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.op    = OP_SUM;
        state_nxt = S_BIAS;
      end
      S_BIAS: begin
        cmd.op    = OP_BIAS;
        state_nxt = S_ABS;
      end
      S_ABS: begin
        cmd.op    = OP_ABS;
        cnt_nxt   = CNT_W'(Q_W - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op  = OP_DIV;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.op = OP_SCALE;
        if (sel100_r) begin
          state_nxt = S_OUT;
        end else begin
          sel100_nxt = 1'b1;
          state_nxt  = S_BIAS;
        end
      end
      S_OUT: begin
        // wait for the output register to drain
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_PUBLISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sel100_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sel100_r    <= sel100_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- src/pressure_altitude_encoder.sv -----
// A beat with tuser high starts a scan of the table entries (one per cycle) up to the first
// at or above the pressure difference or the last, then interpolation and two roundings on
// one shared restoring divider. No new beat is taken until the result is published; a beat
// with tuser low is taken and produces nothing. The output register holds a result while the
// next beat is taken. Synchronous active-low reset clears the controller and out_tvalid.
module pressure_altitude_encoder
  import pae_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] static_pressure
  input  logic        in_tuser,   // [0] serviceable
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [17:0] pressure_altitude, [35:18] mode_c_altitude
);

  dp_cmd_t                 cmd;
  dp_stat_t                stat;
  logic signed [OUT_W-1:0] pa;
  logic signed [OUT_W-1:0] mc;

  pae_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_service (in_tuser),
    .in_ready   (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  pae_dp u_dp (
    .clk               (clk),
    .cmd               (cmd),
    .static_pressure   (in_tdata[SP_W-1:0]),
    .stat              (stat),
    .pressure_altitude (pa),
    .mode_c_altitude   (mc)
  );

  assign out_tdata = {4'b0, mc, pa};

endmodule

// ----- dv/pressure_altitude_checker.sv -----
module pressure_altitude_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] static_pressure
  input  logic        in_tuser,   // [0] serviceable
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,  // [17:0] pressure_altitude, [35:18] mode_c_altitude
  output int          error_count,
  output int          awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS            = pae_pkg::TABLE_POINTS;
  localparam int STD_PRESS_CINHG = 2992;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic [11:0]        static_pressure;
    logic signed [17:0] pressure_altitude;
    logic signed [17:0] mode_c_altitude;
  } altitude_t;

  // pressure difference from standard (0.01 inHg) vs altitude (0.01 ft)
  longint press_diff [NPTS] = '{
    -841, 0, 305, 586, 841, 1074, 1287, 1478, 1655, 1813, 1962, 2082,
    2196, 2301, 2391, 2471, 2540, 2600, 2651, 2696, 2735, 2768, 2798, 2962
  };
  longint alt_centi_ft [NPTS] = '{
    -885827, 0, 295276, 590551, 885827, 1181102, 1476378, 1771654,
    2066929, 2362205, 2657480, 2952756, 3248031, 3543307, 3838583, 4133858,
    4429134, 4724409, 5019685, 5314961, 5610236, 5905512, 6200787, 10000000
  };

  altitude_t altitude_q [$];
  altitude_t want;
  int        mismatches = 0;

  assign error_count = mismatches;

  // num/den is altitude in 0.01 ft; result is in ft, a multiple of step_ft
  function automatic longint round_altitude(input longint num, input longint den,
                                            input longint step_ft);
    return ((num + 50 * step_ft * den) / (100 * step_ft * den)) * step_ft;
  endfunction

  function automatic altitude_t predict_altitude(input logic [11:0] sp);
    longint    diff, num, den;
    bit        found;
    altitude_t r;
    diff  = STD_PRESS_CINHG - longint'(sp);
    num   = alt_centi_ft[NPTS-1];
    den   = 1;
    found = 1'b0;
    for (int i = 0; i < NPTS; i++) begin
      if (!found && press_diff[i] >= diff) begin
        found = 1'b1;
        if (i == 0) begin
          num = alt_centi_ft[0];
          den = 1;
        end else begin
          den = press_diff[i] - press_diff[i-1];
          if (den <= 0) begin
            num = alt_centi_ft[i];
            den = 1;
          end else begin
            num = alt_centi_ft[i-1] * den
                + (alt_centi_ft[i] - alt_centi_ft[i-1]) * (diff - press_diff[i-1]);
          end
        end
      end
    end
    r.static_pressure   = sp;
    r.pressure_altitude = 18'(round_altitude(num, den, 10));
    r.mode_c_altitude   = 18'(round_altitude(num, den, 100));
    return r;
  endfunction

  function automatic void flag_error(input string what, input logic [11:0] sp,
                                     input logic signed [17:0] exp_v,
                                     input logic signed [17:0] got_v);
    if (mismatches < MAX_REPORTS)
      $display("%0t altitude check: %s for pressure %0d, expected %0d, got %0d",
               $time, what, sp, exp_v, got_v);
    mismatches++;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (altitude_q.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t altitude check: unexpected output beat %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = altitude_q.pop_front();
          if (out_tdata[17:0] !== want.pressure_altitude)
            flag_error("pressure_altitude", want.static_pressure,
                       want.pressure_altitude, out_tdata[17:0]);
          if (out_tdata[35:18] !== want.mode_c_altitude)
            flag_error("mode_c_altitude", want.static_pressure,
                       want.mode_c_altitude, out_tdata[35:18]);
        end
      end
      // samples flagged not serviceable produce nothing
      if (in_tvalid && in_tready && in_tuser)
        altitude_q.push_back(predict_altitude(in_tdata[11:0]));
    end
    awaiting = altitude_q.size();
  end

endmodule

// ----- dv/pressure_altitude_encoder_tb.sv -----
module pressure_altitude_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_SAMPLES = 1027;
  localparam int STALL_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 100;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [39:0] out_tdata;

  int error_count;
  int awaiting;
  int ready_hold = 0;
  bit steady     = 1'b0;  // no idling on either side while set

  pressure_altitude_encoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  pressure_altitude_checker altitude_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .error_count(error_count),
    .awaiting   (awaiting)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  always @(posedge clk) begin
    if (!rst_n || steady) begin
      out_tready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_tready <= ($urandom_range(0, 2) != 0);
      ready_hold <= idle_len();
    end
  end

  task automatic send_sample(input logic [11:0] sp, input logic serviceable);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, sp};
    in_tuser  <= serviceable;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gap = steady ? 0 : idle_len();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
    end
    $display("pressure_altitude_encoder: mismatch");
    $finish;
  end

  initial begin : stimulus
    int          sent;
    int          idx;
    int          sp_val;
    logic        svc;
    sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pressure extremes, table edges and points, rounding around zero
    send_sample(12'd0, 1'b1);     // far above the top of the table
    send_sample(12'd4095, 1'b1);  // far below the bottom, clamped
    send_sample(12'd4000, 1'b1);
    send_sample(12'd3833, 1'b1);  // first table point exactly
    send_sample(12'd3834, 1'b1);  // just below the table
    send_sample(12'd3832, 1'b1);
    send_sample(12'd2992, 1'b1);  // standard pressure, zero altitude
    send_sample(12'd2993, 1'b1);
    send_sample(12'd2991, 1'b1);
    send_sample(12'd2687, 1'b1);
    send_sample(12'd195, 1'b1);
    send_sample(12'd194, 1'b1);
    send_sample(12'd100, 1'b1);
    send_sample(12'd30, 1'b1);    // last table point exactly
    send_sample(12'd29, 1'b1);    // just past the last point
    send_sample(12'd2000, 1'b1);
    send_sample(12'd1000, 1'b1);
    send_sample(12'hAAA, 1'b1);
    send_sample(12'h555, 1'b1);
    send_sample(12'd4095, 1'b0);  // not serviceable: no beat out
    send_sample(12'd0, 1'b0);
    send_sample(12'd2992, 1'b0);
    send_sample(12'd2900, 1'b1);

    while (sent < RANDOM_SAMPLES) begin
      steady = (sent >= 300 && sent < 400) || (sent >= 800 && sent < 850);
      svc = ($urandom_range(0, 7) != 0);
      if ($urandom_range(0, 3) == 0) begin
        // land on or next to a table point
        idx    = $urandom_range(0, pae_pkg::TABLE_POINTS - 1);
        sp_val = 2992 - int'(pae_pkg::rom_p(idx[4:0])) + $urandom_range(0, 6) - 3;
        if (sp_val < 0) sp_val = 0;
        if (sp_val > 4095) sp_val = 4095;
      end else begin
        sp_val = $urandom_range(0, 4095);
      end
      send_sample(sp_val[11:0], svc);
      sent++;
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;
    @(posedge clk);

    wait (awaiting == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && awaiting == 0) begin
      $display("pressure_altitude_encoder: match");
    end else begin
      $display("pressure_altitude_encoder: mismatch");
    end
    $finish;
  end

endmodule
